### sv/tqsjd_pkg.sv
// Shared types and codes for the two-queue shortest-join dispatcher.
package tqsjd_pkg;

  // Width of the client id fields on the ports.
  localparam int CLIENT_ID_W = 16;

  typedef enum logic [1:0] {
    MODE_SERVE_ONE = 2'd0,
    MODE_SERVE_TWO = 2'd1,
    MODE_JOIN      = 2'd2,
    MODE_LEAVE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SERVED   = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_ASSIGNED = 2'd2,
    KIND_DROPPED  = 2'd3
  } kind_t;

  // Queue numbers as they appear on the result port.
  localparam logic [1:0] QNUM_ONE = 2'd1;
  localparam logic [1:0] QNUM_TWO = 2'd2;

  typedef struct packed {
    mode_t                  mode;
    logic [CLIENT_ID_W-1:0] client_id;
  } in_req_t;

  typedef struct packed {
    kind_t                  result_kind;
    logic [CLIENT_ID_W-1:0] served_id;
    logic [1:0]             queue_number;
  } out_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MWRITE,
    ST_SQDATA,
    ST_SMDATA
  } state_t;

endpackage

### sv/tqsjd_member_tbl.sv
// Membership table memory: one row per client id holding valid bit and tag for both queues.
module tqsjd_member_tbl #(
  parameter int ID_BITS = 16,
  parameter int ROW_W   = 66
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic               wr_en,
  input  logic [ID_BITS-1:0] addr,
  input  logic [ROW_W-1:0]   wr_data,
  output logic [ROW_W-1:0]   rd_data,
  output logic               ready
);

  logic [ROW_W-1:0]   mem [2**ID_BITS];
  logic [ROW_W-1:0]   rd_data_r;
  logic [ID_BITS-1:0] clear_idx_r;
  logic               clearing_r;

  // After reset every row is zeroed, one row per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clear_idx_r <= '0;
    end else if (clearing_r) begin
      clear_idx_r <= clear_idx_r + 1'b1;
      if (clear_idx_r == {ID_BITS{1'b1}}) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clear_idx_r] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clearing_r;

endmodule

### sv/two_queue_shortest_join_dispatcher.sv
// Top level of the two-queue shortest-join dispatcher.
//
//   channel   ports                      handshake
//   request   start, busy, in_req        taken at a clock edge with start high and busy low
//   result    out_valid, out_res         shown for one cycle, taken at the edge ending it
//
// A join or a leave keeps busy high for one cycle after it is taken (member table read,
// then write back). A join into a full queue is answered at once and does not raise busy.
// A serve keeps busy high until it has popped a live entry or emptied the queue:
// each pop is a queue store read followed by a member table read of the popped id. A serve
// of an empty queue is answered at once and does not raise busy.
// After reset the member table is cleared one row per cycle, all 2**ID_BITS rows, while
// busy stays high. The result strobe cannot be held off, so nothing ever waits on it.
module two_queue_shortest_join_dispatcher #(
  parameter int ID_BITS     = 16,
  parameter int QUEUE_DEPTH = 1024,
  parameter int TAG_BITS    = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tqsjd_pkg::in_req_t in_req,
  output logic               busy,
  output logic               out_valid,
  output tqsjd_pkg::out_res_t out_res
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int ENT_W = TAG_BITS + 1;             // valid bit over tag
  localparam int ROW_W = 2 * ENT_W;                // queue two entry over queue one entry
  localparam int QE_W  = ID_BITS + TAG_BITS;       // queue store entry: id over tag
  localparam int EXT_W = ID_BITS + tqsjd_pkg::CLIENT_ID_W;

  // Control state.
  tqsjd_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]    head_r [2];
  logic [IDX_W-1:0]    head_nxt [2];
  logic [CNT_W-1:0]    fill_r [2];
  logic [CNT_W-1:0]    fill_nxt [2];
  logic [CNT_W-1:0]    live_r [2];
  logic [CNT_W-1:0]    live_nxt [2];
  logic [TAG_BITS-1:0] seq_tag_r, seq_tag_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Per-request payload registers.
  tqsjd_pkg::mode_t    mode_r, mode_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic                q_r, q_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  tqsjd_pkg::out_res_t out_res_r, out_res_nxt;

  // Queue store: both queues in one memory, the queue number is the top address bit.
  logic [QE_W-1:0]  qstore [2**(IDX_W+1)];
  logic             qs_we, qs_re;
  logic [IDX_W:0]   qs_waddr, qs_raddr;
  logic [QE_W-1:0]  qs_wdata;
  logic [QE_W-1:0]  qs_rdata_r;

  // Member table port.
  logic               mem_re, mem_we, mem_ready;
  logic [ID_BITS-1:0] mem_addr;
  logic [ROW_W-1:0]   mem_wdata, mem_rdata;

  // Decoded request and helpers.
  logic [EXT_W-1:0]    id_ext, served_ext;
  logic [ID_BITS-1:0]  id_in;
  logic                acc;
  logic                join_q, sel_q, cur_q;
  logic [IDX_W-1:0]    cur_head, head_inc;
  logic [CNT_W-1:0]    cur_fill;
  logic [SUM_W-1:0]    tail_sum;
  logic [IDX_W-1:0]    tail;
  logic                full;
  logic [ID_BITS-1:0]  ent_id;
  logic [TAG_BITS-1:0] ent_tag;
  logic [ENT_W-1:0]    row_q;
  logic                match;
  logic [1:0]          qnum;

  // Only the low ID_BITS bits of the client id are significant.
  assign id_ext     = {{ID_BITS{1'b0}}, in_req.client_id};
  assign id_in      = id_ext[ID_BITS-1:0];
  assign ent_id     = qs_rdata_r[QE_W-1:TAG_BITS];
  assign ent_tag    = qs_rdata_r[TAG_BITS-1:0];
  assign served_ext = {{tqsjd_pkg::CLIENT_ID_W{1'b0}}, ent_id};

  assign busy = (state_r != tqsjd_pkg::ST_IDLE) || !mem_ready;
  assign acc  = start && !busy;

  // A join goes to the queue with fewer live ids, queue one on a tie.
  assign join_q = (live_r[0] <= live_r[1]) ? 1'b0 : 1'b1;
  assign sel_q  = (in_req.mode == tqsjd_pkg::MODE_JOIN) ? join_q : in_req.mode[0];
  assign cur_q  = (state_r == tqsjd_pkg::ST_IDLE) ? sel_q : q_r;
  assign qnum   = cur_q ? tqsjd_pkg::QNUM_TWO : tqsjd_pkg::QNUM_ONE;

  assign cur_head = head_r[cur_q];
  assign cur_fill = fill_r[cur_q];
  assign head_inc = (cur_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign full     = (cur_fill == CNT_W'(QUEUE_DEPTH));

  // Tail index is head plus fill, wrapped once at the queue depth.
  always_comb begin
    tail_sum = SUM_W'(cur_head) + SUM_W'(cur_fill);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  // The popped entry is live only if its id is still valid in this queue with the same tag.
  assign row_q = q_r ? mem_rdata[ROW_W-1:ENT_W] : mem_rdata[ENT_W-1:0];
  assign match = row_q[ENT_W-1] && (row_q[TAG_BITS-1:0] == ent_tag);

  // The member table is addressed by the request id, or by the id of the popped entry.
  always_comb begin
    case (state_r)
      tqsjd_pkg::ST_IDLE:   mem_addr = id_in;
      tqsjd_pkg::ST_MWRITE: mem_addr = id_r;
      default:              mem_addr = ent_id;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tqsjd_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_req.mode)
            tqsjd_pkg::MODE_SERVE_ONE,
            tqsjd_pkg::MODE_SERVE_TWO: begin
              state_nxt = (cur_fill != '0) ? tqsjd_pkg::ST_SQDATA : tqsjd_pkg::ST_IDLE;
            end
            tqsjd_pkg::MODE_JOIN: begin
              state_nxt = full ? tqsjd_pkg::ST_IDLE : tqsjd_pkg::ST_MWRITE;
            end
            tqsjd_pkg::MODE_LEAVE: state_nxt = tqsjd_pkg::ST_MWRITE;
            default:               state_nxt = tqsjd_pkg::ST_IDLE;
          endcase
        end
      end
      tqsjd_pkg::ST_MWRITE: state_nxt = tqsjd_pkg::ST_IDLE;
      tqsjd_pkg::ST_SQDATA: state_nxt = tqsjd_pkg::ST_SMDATA;
      tqsjd_pkg::ST_SMDATA: begin
        if (match || (cur_fill == '0)) begin
          state_nxt = tqsjd_pkg::ST_IDLE;
        end else begin
          state_nxt = tqsjd_pkg::ST_SQDATA;
        end
      end
      default: state_nxt = tqsjd_pkg::ST_IDLE;
    endcase
  end

  // Memory controls, counters and the result register.
  always_comb begin
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    live_nxt      = live_r;
    seq_tag_nxt   = seq_tag_r;
    mode_nxt      = mode_r;
    id_nxt        = id_r;
    q_nxt         = q_r;
    tag_nxt       = tag_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    qs_we         = 1'b0;
    qs_re         = 1'b0;
    qs_waddr      = {cur_q, tail};
    qs_raddr      = {cur_q, cur_head};
    qs_wdata      = {id_in, seq_tag_r};
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = mem_rdata;

    case (state_r)
      tqsjd_pkg::ST_IDLE: begin
        if (acc) begin
          mode_nxt = in_req.mode;
          id_nxt   = id_in;
          q_nxt    = sel_q;
          case (in_req.mode)
            tqsjd_pkg::MODE_SERVE_ONE,
            tqsjd_pkg::MODE_SERVE_TWO: begin
              if (cur_fill != '0) begin
                qs_re           = 1'b1;
                head_nxt[cur_q] = head_inc;
                fill_nxt[cur_q] = cur_fill - 1'b1;
              end else begin
                out_valid_nxt            = 1'b1;
                out_res_nxt.result_kind  = tqsjd_pkg::KIND_EMPTY;
                out_res_nxt.served_id    = '0;
                out_res_nxt.queue_number = qnum;
              end
            end
            tqsjd_pkg::MODE_JOIN: begin
              // The sequence tag advances on every join, dropped ones included.
              tag_nxt     = seq_tag_r;
              seq_tag_nxt = seq_tag_r + 1'b1;
              if (full) begin
                out_valid_nxt            = 1'b1;
                out_res_nxt.result_kind  = tqsjd_pkg::KIND_DROPPED;
                out_res_nxt.served_id    = '0;
                out_res_nxt.queue_number = qnum;
              end else begin
                qs_we           = 1'b1;
                fill_nxt[cur_q] = cur_fill + 1'b1;
                mem_re          = 1'b1;
              end
            end
            tqsjd_pkg::MODE_LEAVE: mem_re = 1'b1;
            default: ;
          endcase
        end
      end

      tqsjd_pkg::ST_MWRITE: begin
        mem_we = 1'b1;
        if (mode_r == tqsjd_pkg::MODE_JOIN) begin
          // Rejoining this queue makes the old entry stale; live_r rises only for a new id.
          if (!row_q[ENT_W-1]) begin
            live_nxt[q_r] = live_r[q_r] + 1'b1;
          end
          if (q_r) begin
            mem_wdata[ROW_W-1:ENT_W] = {1'b1, tag_r};
          end else begin
            mem_wdata[ENT_W-1:0] = {1'b1, tag_r};
          end
          out_valid_nxt            = 1'b1;
          out_res_nxt.result_kind  = tqsjd_pkg::KIND_ASSIGNED;
          out_res_nxt.served_id    = '0;
          out_res_nxt.queue_number = qnum;
        end else begin
          // Leave clears the id in both queues; an absent id changes nothing.
          if (mem_rdata[ENT_W-1]) begin
            mem_wdata[ENT_W-1] = 1'b0;
            if (live_r[0] != '0) begin
              live_nxt[0] = live_r[0] - 1'b1;
            end
          end
          if (mem_rdata[ROW_W-1]) begin
            mem_wdata[ROW_W-1] = 1'b0;
            if (live_r[1] != '0) begin
              live_nxt[1] = live_r[1] - 1'b1;
            end
          end
        end
      end

      tqsjd_pkg::ST_SQDATA: mem_re = 1'b1;

      tqsjd_pkg::ST_SMDATA: begin
        if (match) begin
          mem_we = 1'b1;
          if (q_r) begin
            mem_wdata[ROW_W-1] = 1'b0;
          end else begin
            mem_wdata[ENT_W-1] = 1'b0;
          end
          if (live_r[q_r] != '0) begin
            live_nxt[q_r] = live_r[q_r] - 1'b1;
          end
          out_valid_nxt            = 1'b1;
          out_res_nxt.result_kind  = tqsjd_pkg::KIND_SERVED;
          out_res_nxt.served_id    = served_ext[tqsjd_pkg::CLIENT_ID_W-1:0];
          out_res_nxt.queue_number = qnum;
        end else if (cur_fill != '0) begin
          // Stale entry: drop it and pop the next one.
          qs_re           = 1'b1;
          head_nxt[cur_q] = head_inc;
          fill_nxt[cur_q] = cur_fill - 1'b1;
        end else begin
          // Only stale entries were left; they are gone now and the queue is empty.
          out_valid_nxt            = 1'b1;
          out_res_nxt.result_kind  = tqsjd_pkg::KIND_EMPTY;
          out_res_nxt.served_id    = '0;
          out_res_nxt.queue_number = qnum;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tqsjd_pkg::ST_IDLE;
      head_r[0]   <= '0;
      head_r[1]   <= '0;
      fill_r[0]   <= '0;
      fill_r[1]   <= '0;
      live_r[0]   <= '0;
      live_r[1]   <= '0;
      seq_tag_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      live_r      <= live_nxt;
      seq_tag_r   <= seq_tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    id_r      <= id_nxt;
    q_r       <= q_nxt;
    tag_r     <= tag_nxt;
    out_res_r <= out_res_nxt;
  end

  // Queue store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (qs_we) begin
      qstore[qs_waddr] <= qs_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (qs_re) begin
      qs_rdata_r <= qstore[qs_raddr];
    end
  end

  tqsjd_member_tbl #(
    .ID_BITS(ID_BITS),
    .ROW_W  (ROW_W)
  ) u_member (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (mem_re),
    .wr_en  (mem_we),
    .addr   (mem_addr),
    .wr_data(mem_wdata),
    .rd_data(mem_rdata),
    .ready  (mem_ready)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### sv/tqsjd_checker.sv
// Port-level checker for the dispatcher and the bind that attaches it.
module tqsjd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input tqsjd_pkg::in_req_t  in_req,
  input logic                out_valid,
  input tqsjd_pkg::out_res_t out_res
);

  // Every result names queue one or queue two.
  a_qnum_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.queue_number == tqsjd_pkg::QNUM_ONE) ||
                  (out_res.queue_number == tqsjd_pkg::QNUM_TWO))
    else $error("result queue number out of range");

  // Only a served result carries an id.
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.result_kind != tqsjd_pkg::KIND_SERVED)) |->
      (out_res.served_id == '0))
    else $error("served id set on a result that serves nobody");

  // A result follows either a taken request or a cycle of work.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result strobe without a request in flight");

  // A leave gives no result in the next cycle.
  a_leave_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.mode == tqsjd_pkg::MODE_LEAVE)) |=> !out_valid)
    else $error("leave produced a result");

endmodule

bind two_queue_shortest_join_dispatcher tqsjd_checker u_tqsjd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_req   (in_req),
  .out_valid(out_valid),
  .out_res  (out_res)
);
